@@ rtl/lsmfd_pkg.sv @@
// Shared types, constants and segment table for the LCD segment meter frame decoder.
package lsmfd_pkg;

  localparam int unsigned FrameBytes  = 14;
  localparam int unsigned HeldNibbles = FrameBytes - 1;
  localparam int unsigned CountWidth  = $clog2(FrameBytes);

  localparam logic [3:0] EndMarker  = 4'hE;
  localparam logic [3:0] BadDigit   = 4'hF;
  localparam logic [6:0] SegOverflow = 7'h68;

  localparam logic [6:0] Seg0 = 7'h7d;
  localparam logic [6:0] Seg1 = 7'h05;
  localparam logic [6:0] Seg2 = 7'h5b;
  localparam logic [6:0] Seg3 = 7'h1f;
  localparam logic [6:0] Seg4 = 7'h27;
  localparam logic [6:0] Seg5 = 7'h3e;
  localparam logic [6:0] Seg6 = 7'h7e;
  localparam logic [6:0] Seg7 = 7'h15;
  localparam logic [6:0] Seg8 = 7'h7f;
  localparam logic [6:0] Seg9 = 7'h3f;

  localparam int unsigned TdataWidth = 64;

  typedef enum logic [2:0] {
    PrefixNone  = 3'd0,
    PrefixKilo  = 3'd1,
    PrefixNano  = 3'd2,
    PrefixMicro = 3'd3,
    PrefixMega  = 3'd4,
    PrefixMilli = 3'd5
  } prefix_e;

  typedef enum logic [2:0] {
    UnitNone    = 3'd0,
    UnitOhm     = 3'd1,
    UnitFarad   = 3'd2,
    UnitHertz   = 3'd3,
    UnitVolt    = 3'd4,
    UnitAmpere  = 3'd5,
    UnitCelsius = 3'd6,
    UnitPercent = 3'd7
  } unit_e;

  typedef enum logic [2:0] {
    ModeDiode       = 3'd0,
    ModeAc          = 3'd1,
    ModeDc          = 3'd2,
    ModeOhm         = 3'd3,
    ModeCapacitance = 3'd4,
    ModeFrequency   = 3'd5,
    ModeTemperature = 3'd6,
    ModeDuty        = 3'd7
  } mode_e;

  typedef struct packed {
    logic [14:0] range_min;
    logic [13:0] range_max;
    mode_e       mode;
    unit_e       unit;
    prefix_e     prefix;
    logic        low_battery;
    logic        overflow;
    logic [1:0]  point_position;
    logic [15:0] digits;
    logic        negative;
  } result_t;

  localparam int unsigned ResultWidth = $bits(result_t);

  function automatic logic [3:0] seg_to_digit(input logic [6:0] pat);
    logic [3:0] dig;
    unique case (pat)
      Seg0:    dig = 4'd0;
      Seg1:    dig = 4'd1;
      Seg2:    dig = 4'd2;
      Seg3:    dig = 4'd3;
      Seg4:    dig = 4'd4;
      Seg5:    dig = 4'd5;
      Seg6:    dig = 4'd6;
      Seg7:    dig = 4'd7;
      Seg8:    dig = 4'd8;
      Seg9:    dig = 4'd9;
      default: dig = BadDigit;
    endcase
    return dig;
  endfunction

endpackage

@@ rtl/lsmfd_decode.sv @@
// Combinational decode of a complete frame of nibbles into display fields and range.
module lsmfd_decode (
  input  logic [lsmfd_pkg::HeldNibbles-1:0][3:0] nibbles_i,
  input  logic [3:0]                             last_nibble_i,
  output lsmfd_pkg::result_t                     result_o
);

  logic [lsmfd_pkg::FrameBytes-1:0][3:0] n;

  always_comb begin
    n = {last_nibble_i, nibbles_i};
  end

  always_comb begin
    logic [6:0]           pat;
    logic [15:0]          dig;
    logic                 ovf;
    logic [1:0]           dp;
    logic [13:0]          rmax;
    logic [13:0]          fcap;
    logic [13:0]          vcap;
    logic [14:0]          rmin;
    lsmfd_pkg::prefix_e   pre;
    lsmfd_pkg::unit_e     un;
    lsmfd_pkg::mode_e     md;

    dig  = '0;
    ovf  = 1'b0;
    dp   = 2'd0;
    rmax = 14'd4000;
    fcap = 14'd10000;
    rmin = '0;

    for (int i = 0; i < 4; i++) begin
      pat = {n[1 + 2 * i][2:0], n[2 + 2 * i]};
      if (pat == lsmfd_pkg::SegOverflow) begin
        ovf = 1'b1;
      end
      dig[15 - 4 * i -: 4] = lsmfd_pkg::seg_to_digit(pat);
    end

    if (n[3][3]) begin
      rmax = 14'd4;
      fcap = 14'd10;
      dp   = 2'd1;
    end
    if (n[5][3]) begin
      rmax = 14'd40;
      fcap = 14'd100;
      dp   = 2'd2;
    end
    if (n[7][3]) begin
      rmax = 14'd400;
      fcap = 14'd1000;
      dp   = 2'd3;
    end

    if (n[9][1]) begin
      pre = lsmfd_pkg::PrefixKilo;
    end else if (n[9][2]) begin
      pre = lsmfd_pkg::PrefixNano;
    end else if (n[9][3]) begin
      pre = lsmfd_pkg::PrefixMicro;
    end else if (n[10][1]) begin
      pre = lsmfd_pkg::PrefixMega;
    end else if (n[10][3]) begin
      pre = lsmfd_pkg::PrefixMilli;
    end else begin
      pre = lsmfd_pkg::PrefixNone;
    end

    vcap = n[0][3] ? 14'd750 : 14'd1000;
    if (n[11][2]) begin
      un = lsmfd_pkg::UnitOhm;
    end else if (n[11][3]) begin
      un = lsmfd_pkg::UnitFarad;
    end else if (n[12][1]) begin
      un = lsmfd_pkg::UnitHertz;
    end else if (n[12][2]) begin
      un = lsmfd_pkg::UnitVolt;
      if (pre == lsmfd_pkg::PrefixNone && rmax > vcap) begin
        rmax = vcap;
      end
    end else if (n[12][3]) begin
      un = lsmfd_pkg::UnitAmpere;
      if (pre == lsmfd_pkg::PrefixNone && rmax > 14'd20) begin
        rmax = 14'd20;
      end
    end else if (n[13][0]) begin
      un = lsmfd_pkg::UnitCelsius;
    end else if (n[10][2]) begin
      un = lsmfd_pkg::UnitPercent;
    end else begin
      un = lsmfd_pkg::UnitNone;
    end

    if (n[9][0]) begin
      rmax = 14'd4;
      md   = lsmfd_pkg::ModeDiode;
    end else if (n[12][3:2] != 2'b00) begin
      if (n[0][3]) begin
        md = lsmfd_pkg::ModeAc;
      end else begin
        md   = lsmfd_pkg::ModeDc;
        rmin = 15'd0 - {1'b0, rmax};
      end
    end else if (n[11][2]) begin
      md = lsmfd_pkg::ModeOhm;
    end else if (n[11][3]) begin
      md = lsmfd_pkg::ModeCapacitance;
    end else if (n[12][1]) begin
      md   = lsmfd_pkg::ModeFrequency;
      rmax = fcap;
    end else if (n[13][0]) begin
      md   = lsmfd_pkg::ModeTemperature;
      rmin = 15'd0 - 15'd50;
      rmax = 14'd250;
    end else begin
      md   = lsmfd_pkg::ModeDuty;
      rmax = 14'd100;
    end

    result_o.range_min      = rmin;
    result_o.range_max      = rmax;
    result_o.mode           = md;
    result_o.unit           = un;
    result_o.prefix         = pre;
    result_o.low_battery    = n[12][0];
    result_o.overflow       = ovf;
    result_o.point_position = dp;
    result_o.digits         = dig;
    result_o.negative       = n[1][3];
  end

endmodule

@@ rtl/lcd_segment_meter_frame_decoder.sv @@
// Top level: byte framing, nibble store and registered result stream of the meter frame decoder.
//
//  channel | direction | tdata                                  | tuser
//  s_axis  | in        | rx_byte[7:0]                           | rx_error
//  m_axis  | out       | frame fields, see m_axis_tdata comment | has_value
//
// One transaction per cycle on s_axis while s_axis_tready is high; the nibble
// store and byte counter update at the accepting edge, and a frame end or
// rejection loads the result register in the same edge. s_axis_tready is high
// whenever the result register is empty or being drained. Reset clears the byte
// counter and result valid; stored nibbles are rewritten before each decode.
module lcd_segment_meter_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rx_byte
  input  logic [7:0]  s_axis_tdata,
  // [0] rx_error
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] negative, [16:1] digits, [18:17] point_position, [19] overflow,
  // [20] low_battery, [23:21] prefix, [26:24] unit, [29:27] mode,
  // [43:30] range_max, [58:44] range_min, [63:59] zero
  output logic [63:0] m_axis_tdata,
  // [0] has_value
  output logic [0:0]  m_axis_tuser
);

  logic [lsmfd_pkg::CountWidth-1:0]              count_q, count_d;
  logic [lsmfd_pkg::HeldNibbles-1:0][3:0]        nibbles_q;
  logic                                          out_valid_q, out_valid_d;
  logic                                          has_value_q;
  lsmfd_pkg::result_t                            result_q;
  lsmfd_pkg::result_t                            decoded;

  logic accept;
  logic marker;
  logic at_last;
  logic store;
  logic produce;
  logic good;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign marker        = (s_axis_tdata[7:4] == lsmfd_pkg::EndMarker);
  assign at_last       = (count_q >= lsmfd_pkg::CountWidth'(lsmfd_pkg::HeldNibbles));

  always_comb begin
    store   = 1'b0;
    produce = 1'b0;
    good    = 1'b0;
    count_d = count_q;
    if (accept) begin
      if (s_axis_tuser[0]) begin
        produce = 1'b1;
        count_d = '0;
      end else if (!at_last) begin
        if (marker) begin
          produce = 1'b1;
          count_d = '0;
        end else begin
          store   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end else begin
        produce = 1'b1;
        good    = marker;
        count_d = '0;
      end
    end
    out_valid_d = (out_valid_q && !m_axis_tready) || produce;
  end

  lsmfd_decode u_decode (
    .nibbles_i     (nibbles_q),
    .last_nibble_i (s_axis_tdata[3:0]),
    .result_o      (decoded)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      nibbles_q[count_q] <= s_axis_tdata[3:0];
    end
    if (produce) begin
      has_value_q <= good;
      result_q    <= good ? decoded : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = has_value_q;
  assign m_axis_tdata  = {(lsmfd_pkg::TdataWidth - lsmfd_pkg::ResultWidth)'(0), result_q};

endmodule
